// File: src/sgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Shared types and constants for the Sobel magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

	localparam int DefMaxWidth    = 1024;
	localparam int DefMaxChannels = 4;

	localparam logic [1:0] CFG_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_CHANNELS = 2'd2;

	typedef struct packed {
		logic [7:0] sample;
		logic       flush;
	} sgm_in_t;

	typedef struct packed {
		logic [7:0] magnitude;
		logic       last_in_run;
		logic       end_of_frame;
	} sgm_out_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic compute_two;
		logic sqrt_start;
		logic sel_second;
	} sgm_cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic has_first;
		logic has_second;
	} sgm_sts_t;

endpackage
`default_nettype wire

// File: src/sobel_gradient_magnitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel gradient magnitude
// Streaming 3x3 Sobel magnitude over raster samples with interleaved channels.
// ----------------------------------------------------------------------------
// The input channel carries one sample per transfer (in_item, in_valid,
// in_stall); a flush item stands for a zero sample below the image. After the
// frame one row of flush items pushes out the bottom row of results.
// Each input transfer yields zero, one or two results on the output channel
// (out_item, out_valid, out_stall); last_in_run marks the last of them.
// Load, line store read and window update come first; each result then
// starts the bit-serial root, waits for it and is transferred; an item whose
// only result is the last column of a one-column row passes the root state
// twice. One item is in flight at a time; the input stalls until its last
// result is transferred. A stalled result holds until taken.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) to width,
// height or channels restart the frame; cfg_ready is high only while no item is in flight.
// After reset the registers hold width 640, height 480 and one channel and
// the counters and window are clear; the line stores need no clearing.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
	import sgm_pkg::*;
#(
	parameter int MaxWidth    = DefMaxWidth,
	parameter int MaxChannels = DefMaxChannels
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire sgm_in_t in_item,
	input  wire         in_valid,
	output logic        in_stall,
	output sgm_out_t    out_item,
	output logic        out_valid,
	input  wire         out_stall,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  chan_q;
	logic        cfg_we;
	logic        restart;
	logic        ctrl_idle;
	sgm_cmd_t    cmd;
	sgm_sts_t    sts;

	assign cfg_ready = ctrl_idle;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
		cfg_index == CFG_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 16'd480;
			chan_q   <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:    width_q  <= cfg_data[10:0];
				CFG_HEIGHT:   height_q <= cfg_data;
				CFG_CHANNELS: chan_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	sgm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cfg_busy(cfg_valid),
		.idle(ctrl_idle), .sts(sts), .cmd(cmd)
	);

	sgm_datapath #(.MaxWidth(MaxWidth), .MaxChannels(MaxChannels)) u_dp (
		.clk(clk), .arst_n(arst_n), .restart(restart), .width_cfg(width_q),
		.height_cfg(height_q), .chan_cfg(chan_q), .in_item(in_item), .cmd(cmd),
		.sts(sts), .result(out_item)
	);

endmodule
`default_nettype wire

// File: src/sgm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sgm_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/sgm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating integer square root
// Bit-serial restoring root of a 17-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sgm_sqrt (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [16:0] value,
	output logic        busy,
	output logic [7:0]  root
);

	logic [16:0] val_q;
	logic [7:0]  root_q;
	logic [7:0]  bit_q;
	logic        sat_q;
	logic [7:0]  trial;
	logic [15:0] sq;

	assign trial = root_q | bit_q;
	assign sq    = trial * trial;
	assign busy  = (bit_q != 8'd0);
	assign root  = sat_q ? 8'hFF : root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 8'd0;
		end else if (start) begin
			bit_q <= 8'h80;
		end else begin
			bit_q <= bit_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			root_q <= 8'd0;
			sat_q  <= value[16];
		end else if (busy && ({1'b0, sq} <= val_q)) begin
			root_q <= trial;
		end
	end

endmodule
`default_nettype wire

// File: src/sgm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel datapath
// Position counters, line stores, window columns, gradient and root unit.
// ----------------------------------------------------------------------------
module sgm_datapath
	import sgm_pkg::*;
#(
	parameter int MaxWidth    = DefMaxWidth,
	parameter int MaxChannels = DefMaxChannels
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            restart,
	input  wire [10:0]     width_cfg,
	input  wire [15:0]     height_cfg,
	input  wire [2:0]      chan_cfg,
	input  wire sgm_in_t   in_item,
	input  wire sgm_cmd_t  cmd,
	output sgm_sts_t       sts,
	output sgm_out_t       result
);

	localparam int ColW  = $clog2(MaxWidth);
	localparam int ChW   = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
	localparam int Depth = MaxWidth * (1 << ChW);
	localparam int AddrW = $clog2(Depth);

	logic [ColW:0]   eff_w;
	logic [15:0]     eff_h;
	logic [2:0]      eff_c;
	logic [16:0]     row_q;
	logic [ColW-1:0] col_q;
	logic [ChW-1:0]  ch_q;
	logic [AddrW-1:0] addr;
	logic [7:0]      up_rd, lo_rd;
	logic [7:0]      cur_q;
	logic [16:0]     row_s1;
	logic [ColW-1:0] col_s1;
	logic [ChW-1:0]  ch_s1;
	logic [7:0]      win_q [MaxChannels][3][2];
	logic [7:0]      lf [3];
	logic [7:0]      md [3];
	logic [7:0]      nw [3];
	logic [7:0]      a [3];
	logic [7:0]      b [3];
	logic [7:0]      cc [3];
	logic [10:0]     rsum, lsum, tsum, bsum;
	logic [10:0]     gx_q, gy_q, gx2_q, gy2_q;
	logic [10:0]     ax, ay;
	logic [16:0]     sq_in;
	logic            first_q, second_q, eof_q;
	logic            last_col;
	logic            outside;
	logic [7:0]      root;
	logic            busy;

	always_comb begin
		eff_w = (width_cfg == 11'd0) ? (ColW+1)'(1) :
			(int'(width_cfg) > MaxWidth) ? (ColW+1)'(MaxWidth) : (ColW+1)'(width_cfg);
		eff_h = (height_cfg == 16'd0) ? 16'd1 : height_cfg;
		eff_c = (chan_cfg == 3'd0) ? 3'd1 :
			(chan_cfg > 3'(MaxChannels)) ? 3'(MaxChannels) : chan_cfg;
	end

	assign addr    = {col_s1, ch_s1};
	assign outside = in_item.flush || (row_q >= {1'b0, eff_h});

	sgm_ram #(.Width(8), .Depth(Depth)) u_upper (
		.clk(clk), .we(cmd.capture), .waddr(addr), .wdata(lo_rd),
		.raddr(addr), .rdata(up_rd)
	);
	sgm_ram #(.Width(8), .Depth(Depth)) u_lower (
		.clk(clk), .we(cmd.capture), .waddr(addr), .wdata(cur_q),
		.raddr(addr), .rdata(lo_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= outside ? 8'd0 : in_item.sample;
			row_s1 <= row_q;
			col_s1 <= col_q;
			ch_s1  <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (cmd.load) begin
			if (3'(ch_q) + 3'd1 >= eff_c) begin
				ch_q <= '0;
				if ((ColW+1)'(col_q) + 1 >= eff_w) begin
					col_q <= '0;
					row_q <= (row_q >= {1'b0, eff_h}) ? '0 : row_q + 17'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	always_comb begin
		nw[0] = (row_s1 >= 17'd2) ? up_rd : 8'd0;
		nw[1] = (row_s1 >= 17'd1) ? lo_rd : 8'd0;
		nw[2] = cur_q;
		for (int k = 0; k < 3; k++) begin
			lf[k] = (col_s1 == '0) ? 8'd0 : win_q[ch_s1][k][0];
			md[k] = (col_s1 == '0) ? 8'd0 : win_q[ch_s1][k][1];
		end
		// After the window update the left column holds the old middle column.
		for (int k = 0; k < 3; k++) begin
			a[k]  = lf[k];
			b[k]  = cmd.compute_two ? nw[k] : md[k];
			cc[k] = cmd.compute_two ? 8'd0 : nw[k];
		end
		rsum = 11'(cc[0]) + 11'({cc[1], 1'b0}) + 11'(cc[2]);
		lsum = 11'(a[0]) + 11'({a[1], 1'b0}) + 11'(a[2]);
		tsum = 11'(a[0]) + 11'({b[0], 1'b0}) + 11'(cc[0]);
		bsum = 11'(a[2]) + 11'({b[2], 1'b0}) + 11'(cc[2]);
		last_col = ((ColW+1)'(col_s1) + 1 >= eff_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '{default: '{default: '{default: 8'd0}}};
		end else if (restart) begin
			win_q <= '{default: '{default: '{default: 8'd0}}};
		end else if (cmd.capture) begin
			for (int k = 0; k < 3; k++) begin
				win_q[ch_s1][k][0] <= md[k];
				win_q[ch_s1][k][1] <= nw[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gx_q     <= (rsum >= lsum) ? rsum - lsum : lsum - rsum;
			gy_q     <= (tsum >= bsum) ? tsum - bsum : bsum - tsum;
			first_q  <= (row_s1 >= 17'd1) && (col_s1 != '0);
			second_q <= (row_s1 >= 17'd1) && last_col;
			eof_q    <= (row_s1 == {1'b0, eff_h}) && last_col && (3'(ch_s1) + 3'd1 >= eff_c);
		end
		if (cmd.compute_two) begin
			gx2_q <= (rsum >= lsum) ? rsum - lsum : lsum - rsum;
			gy2_q <= (tsum >= bsum) ? tsum - bsum : bsum - tsum;
		end
	end

	assign ax    = cmd.sel_second ? gx2_q : gx_q;
	assign ay    = cmd.sel_second ? gy2_q : gy_q;
	assign sq_in = (ax >= 11'd256 || ay >= 11'd256) ? 17'h10000 :
		17'(ax[7:0] * ax[7:0]) + 17'(ay[7:0] * ay[7:0]);

	sgm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .value(sq_in),
		.busy(busy), .root(root)
	);

	assign sts.sqrt_busy  = busy;
	assign sts.has_first  = first_q;
	assign sts.has_second = second_q;

	always_comb begin
		result.magnitude    = root;
		result.last_in_run  = cmd.sel_second || !second_q;
		result.end_of_frame = eof_q && (cmd.sel_second || !second_q);
	end

endmodule
`default_nettype wire

// File: src/sgm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel controller
// Sequences one item through load, window update, root and output transfer.
// ----------------------------------------------------------------------------
module sgm_ctrl
	import sgm_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire       out_stall,
	input  wire       cfg_busy,
	output logic      idle,
	input  wire sgm_sts_t sts,
	output sgm_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_CAPT  = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_SEND  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       second_q, second_d;

	assign in_stall  = (state_q != ST_IDLE) || cfg_busy;
	assign out_valid = (state_q == ST_SEND);
	assign idle      = (state_q == ST_IDLE);

	always_comb begin
		state_d          = state_q;
		second_d         = second_q;
		cmd              = '0;
		cmd.sel_second   = second_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !cfg_busy) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: state_d = ST_CAPT;
			ST_CAPT: begin
				cmd.capture     = 1'b1;
				cmd.sel_second  = 1'b0;
				state_d         = ST_ROOT;
				second_d        = 1'b0;
			end
			ST_ROOT: begin
				if (!second_q) begin
					cmd.compute_two = 1'b1;
					if (sts.has_first) begin
						cmd.sqrt_start = 1'b1;
						state_d = ST_WAIT;
					end else if (sts.has_second) begin
						second_d = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: if (!sts.sqrt_busy) state_d = ST_SEND;
			ST_SEND: begin
				if (!out_stall) begin
					if (!second_q && sts.has_second) begin
						second_d = 1'b1;
						state_d  = ST_ROOT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE) else $error("load while busy");
	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !sts.sqrt_busy) else $error("root still running");

endmodule
`default_nettype wire

// File: bench/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel gradient magnitude testbench
// Streams frames of interleaved samples through the block under many register
// settings, predicts every result with a behavioral model of the window, line
// stores and integer root, and checks each result transfer in order while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_tb;
	import sgm_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	sgm_in_t     in_item;
	logic        in_valid;
	logic        in_stall;
	sgm_out_t    out_item;
	logic        out_valid;
	logic        out_stall;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	sobel_gradient_magnitude uut (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
		.out_item(out_item), .out_valid(out_valid), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sgm_in_t  sample_queue[$];
	sgm_out_t expected_mags[$];
	int       error_count = 0;
	int       stream_count = 0;
	int       results_seen = 0;

	logic [10:0] reg_width;
	logic [15:0] reg_height;
	logic [2:0]  reg_channels;
	logic [7:0]  rows_above [0:4095];
	logic [7:0]  rows_prev  [0:4095];
	logic [7:0]  window [0:3][0:2][0:1];
	int unsigned pos_row, pos_col, pos_chan;

	logic in_fire, out_fire;
	int   in_gap = 0, out_gap = 0, out_hold = 0;
	logic in_calm = 0, out_calm = 0;
	logic hold_done = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("sobel_gradient_magnitude test failed");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic int unsigned eff_width();
		return (reg_width == 0) ? 1 : ((reg_width > DefMaxWidth) ? DefMaxWidth : reg_width);
	endfunction

	function automatic int unsigned eff_height();
		return (reg_height == 0) ? 1 : reg_height;
	endfunction

	function automatic int unsigned eff_chans();
		return (reg_channels == 0) ? 1 :
			((reg_channels > DefMaxChannels) ? DefMaxChannels : reg_channels);
	endfunction

	function automatic logic [7:0] grad_mag(input logic [2:0][7:0] lf, input logic [2:0][7:0] md,
			input logic [2:0][7:0] rt);
		int gx, gy;
		int unsigned s, root, t;
		gx = (int'(rt[0]) + 2 * int'(rt[1]) + int'(rt[2]))
			- (int'(lf[0]) + 2 * int'(lf[1]) + int'(lf[2]));
		gy = (int'(lf[0]) + 2 * int'(md[0]) + int'(rt[0]))
			- (int'(lf[2]) + 2 * int'(md[2]) + int'(rt[2]));
		s = gx * gx + gy * gy;
		if (s >= 65536) return 8'd255;
		root = 0;
		for (int b = 128; b > 0; b = b >> 1) begin
			t = root | b;
			if (t * t <= s) root = t;
		end
		return root[7:0];
	endfunction

	task automatic restart_frame();
		for (int a = 0; a < 4; a++)
			for (int k = 0; k < 3; k++) begin
				window[a][k][0] = 0;
				window[a][k][1] = 0;
			end
		pos_row = 0;
		pos_col = 0;
		pos_chan = 0;
	endtask

	task automatic predict_results(input sgm_in_t it);
		int unsigned w, h, c, r, cl, k2, addr;
		logic [7:0] cur;
		logic [2:0][7:0] lf, md, nw;
		logic last_col;
		int n;
		sgm_out_t res [0:1];
		w = eff_width();
		h = eff_height();
		c = eff_chans();
		r = pos_row;
		cl = pos_col;
		k2 = pos_chan;
		if (cl >= w) cl = w - 1;
		if (k2 >= c) k2 = c - 1;
		cur = (it.flush || r >= h) ? 8'd0 : it.sample;
		addr = cl * 4 + k2;
		nw[0] = (r >= 2) ? rows_above[addr] : 8'd0;
		nw[1] = (r >= 1) ? rows_prev[addr] : 8'd0;
		nw[2] = cur;
		rows_above[addr] = rows_prev[addr];
		rows_prev[addr] = cur;
		if (cl == 0)
			for (int k = 0; k < 3; k++) begin
				window[k2][k][0] = 0;
				window[k2][k][1] = 0;
			end
		for (int k = 0; k < 3; k++) begin
			lf[k] = window[k2][k][0];
			md[k] = window[k2][k][1];
		end
		last_col = (cl + 1 >= w);
		n = 0;
		if (r >= 1) begin
			if (cl >= 1) begin
				res[n] = '0;
				res[n].magnitude = grad_mag(lf, md, nw);
				n++;
			end
			if (last_col) begin
				res[n] = '0;
				res[n].magnitude = grad_mag(md, nw, '0);
				n++;
			end
			if (n > 0) begin
				res[n-1].last_in_run = 1'b1;
				if (r == h && last_col && k2 + 1 >= c) res[n-1].end_of_frame = 1'b1;
			end
			for (int i = 0; i < n; i++) expected_mags = {expected_mags, res[i]};
		end
		for (int k = 0; k < 3; k++) begin
			window[k2][k][0] = md[k];
			window[k2][k][1] = nw[k];
		end
		k2++;
		if (k2 >= c) begin
			k2 = 0;
			cl++;
			if (cl >= w) begin
				cl = 0;
				r++;
				if (r > h) r = 0;
			end
		end
		pos_chan = k2;
		pos_col = cl;
		pos_row = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire <= 0;
			out_fire <= 0;
		end else begin
			in_fire <= in_valid && !in_stall;
			out_fire <= out_valid && !out_stall;
			if (in_valid && !in_stall) predict_results(in_item);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_mags.size() == 0) begin
					report("unexpected result transfer", out_item.magnitude, 0);
				end else begin
					sgm_out_t want;
					want = expected_mags.pop_front();
					if (out_item.magnitude !== want.magnitude)
						report("magnitude", out_item.magnitude, want.magnitude);
					if (out_item.last_in_run !== want.last_in_run)
						report("last_in_run", out_item.last_in_run, want.last_in_run);
					if (out_item.end_of_frame !== want.end_of_frame)
						report("end_of_frame", out_item.end_of_frame, want.end_of_frame);
				end
			end
		end
	end

	always @(negedge clk) begin
		logic nv;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && in_fire) begin
				nv = 0;
				if ($urandom_range(0, 40) == 0) in_calm = ~in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 11);
			end
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (sample_queue.size() > 0) begin
					in_item <= sample_queue.pop_front();
					nv = 1;
				end
			end
			in_valid <= nv;
		end
	end

	// The receiver holds off for a long stretch once while items are still queued.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= 300 && sample_queue.size() > 20) begin
				hold_done = 1;
				out_hold = 400;
			end else if (out_hold > 0) begin
				out_hold--;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 40) == 0) out_calm = ~out_calm;
				out_gap = out_calm ? 0 : $urandom_range(0, 11);
			end
			if (out_hold > 0) begin
				out_stall <= 1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic queue_item(input logic [7:0] s, input logic f);
		sgm_in_t it;
		it.sample = s;
		it.flush = f;
		sample_queue = {sample_queue, it};
		stream_count++;
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (sample_queue.size() != 0 || in_valid || expected_mags.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_WIDTH: reg_width = data[10:0];
			CFG_HEIGHT: reg_height = data;
			CFG_CHANNELS: reg_channels = data[2:0];
			default: ;
		endcase
		if (idx != CFG_UNUSED) restart_frame();
		@(negedge clk);
		cfg_valid <= 0;
		cfg_index <= 2'($urandom_range(0, 3));
		cfg_data <= 16'($urandom_range(0, 65535));
	endtask

	task automatic set_shape(input int w, input int h, input int c);
		wait_idle();
		write_reg(CFG_WIDTH, 16'(w));
		write_reg(CFG_HEIGHT, 16'(h));
		write_reg(CFG_CHANNELS, 16'(c));
	endtask

	task automatic push_frame(input int flush_pct, input int stop_after);
		int unsigned total;
		int unsigned in_frame;
		total = eff_width() * eff_chans() * (eff_height() + 1);
		in_frame = eff_width() * eff_chans() * eff_height();
		if (stop_after > 0 && stop_after < total) total = stop_after;
		for (int unsigned i = 0; i < total; i++) begin
			if (i < in_frame)
				queue_item(pick_pixel(), $urandom_range(0, 99) < flush_pct);
			else
				queue_item(pick_pixel(), $urandom_range(0, 9) != 0);
		end
	endtask

	initial begin
		int w, h, c;
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = 0;
		reg_width = 640;
		reg_height = 480;
		reg_channels = 1;
		for (int a = 0; a < 4096; a++) begin
			rows_above[a] = 0;
			rows_prev[a] = 0;
		end
		restart_frame();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		set_shape(3, 2, 1);
		queue_item(8'd255, 0); queue_item(8'd0, 0); queue_item(8'd255, 0);
		queue_item(8'd0, 0); queue_item(8'd255, 1); queue_item(8'd0, 0);
		queue_item(8'd255, 0); queue_item(8'd17, 1); queue_item(8'd170, 0);
		set_shape(1, 1, 1);
		queue_item(8'd255, 0); queue_item(8'd85, 0);
		queue_item(8'd255, 0); queue_item(8'd0, 1);
		set_shape(0, 0, 0);
		queue_item(8'd255, 0); queue_item(8'd255, 0);
		set_shape(2047, 1, 7);
		push_frame(3, 60);
		set_shape(1025, 2, 5);
		push_frame(3, 60);
		set_shape(4, 65535, 4);
		push_frame(3, 120);
		wait_idle();
		write_reg(CFG_UNUSED, 16'hFFFF);
		push_frame(3, 40);
		set_shape(1024, 1, 1);
		push_frame(0, 100);

		while (stream_count < 800) begin
			w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 4);
			c = $urandom_range(1, 4);
			set_shape(w, h, c);
			if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
			repeat ($urandom_range(1, 3)) push_frame($urandom_range(0, 1) ? 0 : 10, 0);
			if ($urandom_range(0, 4) == 0) push_frame(10, $urandom_range(1, 20));
		end

		wait_idle();
		if (error_count == 0)
			$display("sobel_gradient_magnitude test passed");
		else
			$display("sobel_gradient_magnitude test failed");
		$finish;
	end

endmodule

// File: filelist.f
src/sgm_pkg.sv
src/sgm_ram.sv
src/sgm_sqrt.sv
src/sgm_datapath.sv
src/sgm_ctrl.sv
src/sobel_gradient_magnitude.sv
bench/sobel_gradient_magnitude_tb.sv
